// File: hw/rtl/ihrg_pkg.sv
`timescale 1ns / 1ps

package ihrg_pkg;

    // Record type codes carried on the record_type port.
    localparam logic [2:0] REC_DATA = 3'd0;
    localparam logic [2:0] REC_EOF  = 3'd1;
    localparam logic [2:0] REC_ELA  = 3'd4;

    // Data byte counts of the three record kinds.
    localparam logic [2:0] CNT_DATA = 3'd4;
    localparam logic [2:0] CNT_EOF  = 3'd0;
    localparam logic [2:0] CNT_ELA  = 3'd2;

    // Configuration register map.
    localparam int unsigned  PADDR_W         = 2;
    localparam logic [1:0]   ADDR_REPEAT_CNT = 2'd0;
    localparam int unsigned  REPEAT_W        = 6;
    localparam logic [5:0]   REPEAT_RESET    = 6'd1;

    // Default depth of the queue between the front and back ends.
    localparam int unsigned  QUEUE_DEPTH_DEF = 4;

    // One classified item, as the front end hands it to the back end.
    typedef struct packed {
        logic                is_eof;
        logic                need_ela;
        logic [15:0]         upper;
        logic [15:0]         addr_low;
        logic [31:0]         value;
        logic [REPEAT_W-1:0] count;
    } ihrg_entry_t;

    // Queue status seen by both ends.
    typedef struct packed {
        logic full;
        logic empty;
    } ihrg_q_status_t;

    // Two's complement of the byte sum of a record.
    function automatic logic [7:0] rec_checksum(
        input logic [2:0]  rtype,
        input logic [2:0]  cnt,
        input logic [15:0] alow,
        input logic [31:0] data
    );
        logic [7:0] sum;
        sum = {5'd0, cnt} + alow[15:8] + alow[7:0] + {5'd0, rtype}
            + data[7:0] + data[15:8] + data[23:16] + data[31:24];
        return 8'(~sum + 8'd1);
    endfunction

endpackage

// File: hw/rtl/ihrg_front.sv
`timescale 1ns / 1ps

module ihrg_front
    import ihrg_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                command,
    input  logic [31:0]         address,
    input  logic [31:0]         value,
    input  logic [REPEAT_W-1:0] repeat_count,
    input  ihrg_q_status_t      q_status,
    output logic                push,
    output ihrg_entry_t         push_entry
);

    logic        accept;
    logic        need_ela;
    logic        produces;
    logic [15:0] upper;
    logic [15:0] cur_upper_reg;
    logic [15:0] cur_upper_next;

    // The front end takes an item whenever the queue has room.
    assign in_stall = q_status.full;
    assign accept   = in_valid && !q_status.full;

    // Classify: an address record is due when the upper half changes.
    assign upper    = address[31:16];
    assign need_ela = !command && (upper != cur_upper_reg);
    assign produces = command || need_ela || (repeat_count != '0);

    // Items that yield no record are taken and dropped here.
    assign push = accept && produces;

    always_comb
    begin
        push_entry.is_eof   = command;
        push_entry.need_ela = need_ela;
        push_entry.upper    = upper;
        push_entry.addr_low = address[15:0];
        push_entry.value    = value;
        push_entry.count    = repeat_count;
    end

    // Finish returns the stored upper half to zero for the next file.
    always_comb
    begin
        cur_upper_next = cur_upper_reg;
        if (accept)
        begin
            cur_upper_next = command ? 16'd0 : upper;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_upper_reg <= '0;
        end
        else
        begin
            cur_upper_reg <= cur_upper_next;
        end
    end

endmodule

// File: hw/rtl/ihrg_queue.sv
`timescale 1ns / 1ps

module ihrg_queue
    import ihrg_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  ihrg_entry_t    push_entry,
    input  logic           pop,
    output ihrg_entry_t    head,
    output ihrg_q_status_t q_status
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

    ihrg_entry_t      entries [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign q_status.full  = (count_reg == FULL_CNT);
    assign q_status.empty = (count_reg == '0);
    assign do_push        = push && !q_status.full;
    assign do_pop         = pop && !q_status.empty;
    assign head           = entries[rd_ptr_reg];

    // Pointer and occupancy update, with wrap at the queue depth.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : PTR_W'(wr_ptr_reg + 1'b1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : PTR_W'(rd_ptr_reg + 1'b1);
        end
        if (do_push && !do_pop)
        begin
            count_next = CNT_W'(count_reg + 1'b1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = CNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// File: hw/rtl/ihrg_back.sv
`timescale 1ns / 1ps

module ihrg_back
    import ihrg_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  ihrg_entry_t    head,
    input  ihrg_q_status_t q_status,
    output logic           pop,
    output logic           out_valid,
    input  logic           out_stall,
    output logic [2:0]     record_type,
    output logic [2:0]     byte_count,
    output logic [15:0]    address_low,
    output logic [31:0]    data_bytes,
    output logic [7:0]     checksum,
    output logic           last_of_run
);

    logic                ela_done_reg;
    logic                ela_done_next;
    logic [REPEAT_W-1:0] sent_reg;
    logic [REPEAT_W-1:0] sent_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [2:0]          type_reg;
    logic [2:0]          cnt_reg;
    logic [15:0]         alow_reg;
    logic [31:0]         data_reg;
    logic [7:0]          csum_reg;
    logic                last_reg;

    logic                emit;
    logic                is_ela;
    logic [REPEAT_W-1:0] sent_inc;
    logic [2:0]          rec_type;
    logic [2:0]          rec_cnt;
    logic [15:0]         rec_alow;
    logic [31:0]         rec_data;
    logic                rec_last;

    // A record moves into the output register when it is free or drains.
    assign emit     = !q_status.empty && (!out_valid_reg || !out_stall);
    assign sent_inc = REPEAT_W'(sent_reg + 1'b1);
    assign is_ela   = !head.is_eof && head.need_ela && !ela_done_reg;

    // Build the next record of the item at the head of the queue.
    always_comb
    begin
        if (head.is_eof)
        begin
            rec_type = REC_EOF;
            rec_cnt  = CNT_EOF;
            rec_alow = '0;
            rec_data = '0;
            rec_last = 1'b1;
        end
        else if (is_ela)
        begin
            rec_type = REC_ELA;
            rec_cnt  = CNT_ELA;
            rec_alow = '0;
            rec_data = {16'd0, head.upper[7:0], head.upper[15:8]};
            rec_last = (head.count == '0);
        end
        else
        begin
            rec_type = REC_DATA;
            rec_cnt  = CNT_DATA;
            rec_alow = head.addr_low;
            rec_data = head.value;
            rec_last = (sent_inc == head.count);
        end
    end

    assign pop = emit && rec_last;

    // Progress through the current item; cleared when it leaves the queue.
    always_comb
    begin
        ela_done_next  = ela_done_reg;
        sent_next      = sent_reg;
        out_valid_next = out_valid_reg;
        if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (emit)
        begin
            out_valid_next = 1'b1;
            if (rec_last)
            begin
                ela_done_next = 1'b0;
                sent_next     = '0;
            end
            else if (is_ela)
            begin
                ela_done_next = 1'b1;
            end
            else
            begin
                sent_next = sent_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ela_done_reg  <= 1'b0;
            sent_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            ela_done_reg  <= ela_done_next;
            sent_reg      <= sent_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            type_reg <= rec_type;
            cnt_reg  <= rec_cnt;
            alow_reg <= rec_alow;
            data_reg <= rec_data;
            csum_reg <= rec_checksum(rec_type, rec_cnt, rec_alow, rec_data);
            last_reg <= rec_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign record_type = type_reg;
    assign byte_count  = cnt_reg;
    assign address_low = alow_reg;
    assign data_bytes  = data_reg;
    assign checksum    = csum_reg;
    assign last_of_run = last_reg;

endmodule

// File: hw/rtl/intel_hex_record_generator.sv
`timescale 1ns / 1ps

// Intel HEX record generator. Each input beat is either an address/value
// pair or a finish command; each output beat is one record as fields with its
// checksum. A pair whose upper address half differs from the last one sent
// first yields an extended linear address record, then repeat_count data
// records; finish yields an end-of-file record and clears the stored upper
// half. The front end accepts one item per clock while its queue
// (QUEUE_DEPTH entries) has room; the back end sends at most one record per
// clock through a single output register, so an item yielding k records
// holds the back end until all k have been sent. When the queue is empty,
// an accepted item is first written into the queue, and its first record is
// then loaded into the output register, where it stays valid until taken.
// The repeat_count register sits at byte address 0 of the APB port and
// resets to 1.
module intel_hex_record_generator
    import ihrg_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               command,
    input  logic [31:0]        address,
    input  logic [31:0]        value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         record_type,
    output logic [2:0]         byte_count,
    output logic [15:0]        address_low,
    output logic [31:0]        data_bytes,
    output logic [7:0]         checksum,
    output logic               last_of_run
);

    logic [REPEAT_W-1:0] repeat_count_reg;
    logic [REPEAT_W-1:0] repeat_count_next;
    logic                cfg_write;
    logic                push;
    logic                pop;
    ihrg_entry_t         push_entry;
    ihrg_entry_t         head;
    ihrg_q_status_t      q_status;

    // Register access: always ready, one register.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr == ADDR_REPEAT_CNT);
    assign prdata    = (paddr == ADDR_REPEAT_CNT) ?
                       {{(32 - REPEAT_W){1'b0}}, repeat_count_reg} : 32'd0;

    always_comb
    begin
        repeat_count_next = repeat_count_reg;
        if (cfg_write)
        begin
            repeat_count_next = pwdata[REPEAT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            repeat_count_reg <= REPEAT_RESET;
        end
        else
        begin
            repeat_count_reg <= repeat_count_next;
        end
    end

    ihrg_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .address      (address),
        .value        (value),
        .repeat_count (repeat_count_reg),
        .q_status     (q_status),
        .push         (push),
        .push_entry   (push_entry)
    );

    ihrg_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .q_status   (q_status)
    );

    ihrg_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .q_status    (q_status),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .record_type (record_type),
        .byte_count  (byte_count),
        .address_low (address_low),
        .data_bytes  (data_bytes),
        .checksum    (checksum),
        .last_of_run (last_of_run)
    );

endmodule

// File: hw/rtl/ihrg_checker.sv
`timescale 1ns / 1ps

module ihrg_checker
    import ihrg_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [2:0]  record_type,
    input logic [2:0]  byte_count,
    input logic [15:0] address_low,
    input logic [31:0] data_bytes,
    input logic [7:0]  checksum,
    input logic        last_of_run
);

    logic [7:0] rec_sum;

    // A whole record, checksum included, sums to zero modulo 256.
    assign rec_sum = {5'd0, byte_count} + address_low[15:8] + address_low[7:0]
                   + {5'd0, record_type} + data_bytes[7:0] + data_bytes[15:8]
                   + data_bytes[23:16] + data_bytes[31:24] + checksum;

    // A stalled output beat holds its record.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(record_type)
            && $stable(data_bytes) && $stable(checksum) && $stable(last_of_run))
        else $error("output record changed while stalled");

    a_checksum: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> rec_sum == 8'd0)
        else $error("record checksum does not balance");

    // End of file is empty and always closes its run.
    a_eof_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && record_type == REC_EOF |-> last_of_run
            && byte_count == CNT_EOF && address_low == 16'd0 && data_bytes == 32'd0)
        else $error("malformed end-of-file record");

    // Address records carry two bytes and no low address.
    a_ela_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && record_type == REC_ELA |-> byte_count == CNT_ELA
            && address_low == 16'd0 && data_bytes[31:16] == 16'd0)
        else $error("malformed extended address record");

    a_data_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && record_type == REC_DATA |-> byte_count == CNT_DATA)
        else $error("malformed data record");

endmodule

bind intel_hex_record_generator ihrg_checker u_ihrg_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .record_type (record_type),
    .byte_count  (byte_count),
    .address_low (address_low),
    .data_bytes  (data_bytes),
    .checksum    (checksum),
    .last_of_run (last_of_run)
);
